>>> hdl/bfiq_pkg.sv
// shared types and constants of the bloom filter block
`default_nettype none

package bfiq_pkg;

  // payload and register widths
  localparam int KEY_W      = 32;
  localparam int HASH_W     = 32;
  localparam int CFG_W      = 17;
  localparam int SIZE_REG_W = 17;
  localparam int HCNT_REG_W = 5;
  localparam int CFG_IDX_W  = 2;

  // defaults of the top level parameters
  localparam int DEF_FILTER_BITS = 65536;
  localparam int DEF_MAX_HASHES  = 16;

  // register values after reset and the lower bound of the modulus
  localparam int RST_FILTER_SIZE = 65536;
  localparam int RST_HASH_COUNT  = 7;
  localparam int MIN_FILTER_SIZE = 8;

  // integer mixing hash
  localparam int MIX_SHL_A = 15;
  localparam int MIX_SHR_A = 12;
  localparam int MIX_SHL_B = 2;
  localparam int MIX_SHR_B = 4;
  localparam int MIX_SHR_C = 16;
  localparam int MIX_MUL_W = 12;
  localparam logic [MIX_MUL_W-1:0] MIX_MUL = 12'd2057;

  // remainder pipeline: bits of the hash consumed per stage
  localparam int MOD_STEP   = 4;
  localparam int MOD_STAGES = HASH_W / MOD_STEP;

  // queue depths
  localparam int CMDQ_DEPTH = 4;
  localparam int RES_DEPTH  = 16;

  // register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FILTER_SIZE = 2'd0,
    CFG_HASH_COUNT  = 2'd1
  } cfg_idx_e;

  // command codes
  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_QUERY  = 1'b1
  } op_e;

  // tag that travels with every probe slot
  typedef struct packed {
    logic query;  // slot belongs to a query item
    logic probe;  // slot addresses a bit (clear for a zero hash count)
    logic last;   // final slot of its item
  } slot_t;

endpackage

`default_nettype wire

>>> hdl/bfiq_fifo.sv
// small register queue used for commands and for results
`default_nettype none

module bfiq_fifo import bfiq_pkg::*; #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic      [WIDTH-1:0] rdata_o,
  output logic                  empty_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wptr_q, wptr_d;
  logic [AW-1:0]    rptr_q, rptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rptr_q];

  // pointer and fill count update
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + AW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

>>> hdl/bfiq_probe_seq.sv
// probe sequencer: takes commands from the front queue and issues one probe per cycle while an item runs
`default_nettype none

module bfiq_probe_seq import bfiq_pkg::*; #(
  parameter int MAX_HASHES = DEF_MAX_HASHES,
  localparam int HC_W = $clog2(MAX_HASHES + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // front queue head
  input  wire logic             item_valid_i,
  input  wire logic             item_cmd_i,
  input  wire logic [KEY_W-1:0] item_key_i,
  output logic                  item_pop_o,
  // configuration and status
  input  wire logic [HC_W-1:0]  hash_count_i,
  input  wire logic             store_busy_i,
  input  wire logic             res_pop_i,
  // probe slots to the hash pipeline
  output logic                  slot_valid_o,
  output slot_t                 slot_o,
  output logic      [KEY_W-1:0] key_o,
  output logic      [HC_W-1:0]  probe_o
);

  localparam int CR_W = $clog2(RES_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } seq_state_e;

  seq_state_e       state_q, state_d;
  logic [KEY_W-1:0] key_q;
  logic             query_q;
  logic [HC_W-1:0]  cnt_q;
  logic [HC_W-1:0]  idx_q, idx_d;
  logic [CR_W-1:0]  credit_q, credit_d;
  logic             is_query, credit_ok, can_load, last_slot, load;

  assign is_query  = (op_e'(item_cmd_i) == OP_QUERY);
  assign credit_ok = (credit_q < CR_W'(RES_DEPTH));
  assign can_load  = item_valid_i & ~store_busy_i & (~is_query | credit_ok);
  assign last_slot = (cnt_q == '0) || (idx_q == cnt_q);

  // next state: a new item may follow right after the last slot of the current one
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    load    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (can_load) begin
          load    = 1'b1;
          state_d = ST_RUN;
          idx_d   = HC_W'(1);
        end
      end
      ST_RUN: begin
        if (last_slot) begin
          if (can_load) begin
            load  = 1'b1;
            idx_d = HC_W'(1);
          end else begin
            state_d = ST_IDLE;
          end
        end else begin
          idx_d = idx_q + HC_W'(1);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // result slots reserved by queries in flight or waiting in the result queue
  always_comb begin
    credit_d = credit_q;
    if ((load && is_query) && !res_pop_i) begin
      credit_d = credit_q + CR_W'(1);
    end else if (!(load && is_query) && res_pop_i) begin
      credit_d = credit_q - CR_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      idx_q    <= '0;
      credit_q <= '0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      credit_q <= credit_d;
    end
  end

  // item latched for the duration of its probes
  always_ff @(posedge clk_i) begin
    if (load) begin
      key_q   <= item_key_i;
      query_q <= is_query;
      cnt_q   <= hash_count_i;
    end
  end

  assign item_pop_o   = load;
  assign slot_valid_o = (state_q == ST_RUN);
  assign slot_o.query = query_q;
  assign slot_o.probe = (cnt_q != '0);
  assign slot_o.last  = last_slot;
  assign key_o        = key_q;
  assign probe_o      = idx_q;

endmodule

`default_nettype wire

>>> hdl/bfiq_hash_pipe.sv
// hash pipeline: probe value, integer mixing hash and pipelined remainder
`default_nettype none

module bfiq_hash_pipe import bfiq_pkg::*; #(
  parameter int FILTER_BITS = DEF_FILTER_BITS,
  parameter int MAX_HASHES  = DEF_MAX_HASHES,
  localparam int HC_W  = $clog2(MAX_HASHES + 1),
  localparam int MOD_W = $clog2(FILTER_BITS + 1),
  localparam int AW    = $clog2(FILTER_BITS)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire slot_t            in_slot_i,
  input  wire logic [KEY_W-1:0] key_i,
  input  wire logic [HC_W-1:0]  probe_i,
  input  wire logic [MOD_W-1:0] modulus_i,
  output logic                  out_valid_o,
  output slot_t                 out_slot_o,
  output logic      [AW-1:0]    index_o
);

  localparam int SQ_W    = 2 * HC_W;
  localparam int MUL_EXT = MIX_MUL_W;

  // one restoring remainder step on the next hash bit
  function automatic logic [MOD_W-1:0] rem_step(logic [MOD_W-1:0] r, logic b,
                                                logic [MOD_W-1:0] m);
    logic [MOD_W:0] t;
    t = {r, b};
    if (t >= {1'b0, m}) begin
      t = t - {1'b0, m};
    end
    return t[MOD_W-1:0];
  endfunction

  logic [SQ_W-1:0]         sq;
  logic [HASH_W+HC_W-1:0]  vmul;
  logic [HASH_W+MUL_EXT-1:0] hmul;
  logic [HASH_W-1:0]       h1, h2, h3, h4, h5, h6;

  logic                    v1_q, v2_q, v3_q, v4_q, v5_q;
  slot_t                   s1_q, s2_q, s3_q, s4_q, s5_q;
  logic [HASH_W-1:0]       d1_q, d2_q, d3_q, d4_q, d5_q;
  logic [HC_W-1:0]         p1_q;

  logic [MOD_STAGES-1:0]   mv_q;
  slot_t                   ms_q   [MOD_STAGES];
  logic [MOD_W-1:0]        rem_q  [MOD_STAGES];
  logic [HASH_W-1:0]       bits_q [MOD_STAGES];

  // probe value: key plus square of the probe number, then times the probe number
  assign sq   = SQ_W'(probe_i) * SQ_W'(probe_i);
  assign vmul = {{HC_W{1'b0}}, d1_q} * {{HASH_W{1'b0}}, p1_q};

  // mixing hash, split over three stages
  assign h1   = ~d2_q + (d2_q << MIX_SHL_A);
  assign h2   = h1 ^ (h1 >> MIX_SHR_A);
  assign h3   = d3_q + (d3_q << MIX_SHL_B);
  assign h4   = h3 ^ (h3 >> MIX_SHR_B);
  assign hmul = {{MUL_EXT{1'b0}}, d4_q} * {{HASH_W{1'b0}}, MIX_MUL};
  assign h5   = hmul[HASH_W-1:0];
  assign h6   = h5 ^ (h5 >> MIX_SHR_C);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q <= in_slot_i;
    d1_q <= key_i + HASH_W'(sq);
    p1_q <= probe_i;
    s2_q <= s1_q;
    d2_q <= vmul[HASH_W-1:0];
    s3_q <= s2_q;
    d3_q <= h2;
    s4_q <= s3_q;
    d4_q <= h4;
    s5_q <= s4_q;
    d5_q <= h6;
  end

  // remainder modulo the filter size, MOD_STEP (four) hash bits per stage
  for (genvar s = 0; s < MOD_STAGES; s++) begin : g_mod
    logic              vin;
    slot_t             sin;
    logic [MOD_W-1:0]  rin, rout;
    logic [HASH_W-1:0] bin, bout;

    if (s == 0) begin : g_first
      assign vin = v5_q;
      assign sin = s5_q;
      assign rin = '0;
      assign bin = d5_q;
    end else begin : g_next
      assign vin = mv_q[s-1];
      assign sin = ms_q[s-1];
      assign rin = rem_q[s-1];
      assign bin = bits_q[s-1];
    end

    always_comb begin
      rout = rin;
      bout = bin;
      for (int k = 0; k < MOD_STEP; k++) begin
        rout = rem_step(rout, bout[HASH_W-1], modulus_i);
        bout = bout << 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        mv_q[s] <= 1'b0;
      end else begin
        mv_q[s] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      ms_q[s]   <= sin;
      rem_q[s]  <= rout;
      bits_q[s] <= bout;
    end
  end

  assign out_valid_o = mv_q[MOD_STAGES-1];
  assign out_slot_o  = ms_q[MOD_STAGES-1];
  assign index_o     = rem_q[MOD_STAGES-1][AW-1:0];

endmodule

`default_nettype wire

>>> hdl/bfiq_bit_store.sv
// filter bit memory with clearing pass, probe access and query result collection
`default_nettype none

module bfiq_bit_store import bfiq_pkg::*; #(
  parameter int FILTER_BITS = DEF_FILTER_BITS,
  localparam int AW = $clog2(FILTER_BITS)
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire slot_t         in_slot_i,
  input  wire logic [AW-1:0] index_i,
  output logic               busy_o,
  output logic               res_valid_o,
  output logic               res_present_o
);

  logic          mem_q [FILTER_BITS];
  logic          clearing_q, clearing_d;
  logic [AW-1:0] clr_addr_q, clr_addr_d;
  logic          we;
  logic [AW-1:0] waddr;
  logic          rd_bit_q;
  logic          rv_q;
  slot_t         rslot_q;
  logic          acc_q, acc_d;
  logic          hit;

  // clearing pass after reset, one bit per cycle
  always_comb begin
    clearing_d = clearing_q;
    clr_addr_d = clr_addr_q;
    if (clearing_q) begin
      clr_addr_d = clr_addr_q + AW'(1);
      if (clr_addr_q == AW'(FILTER_BITS - 1)) begin
        clearing_d = 1'b0;
      end
    end
  end

  // write port: clearing pass or insert probe
  assign we    = clearing_q | (in_valid_i & in_slot_i.probe & ~in_slot_i.query);
  assign waddr = clearing_q ? clr_addr_q : index_i;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= ~clearing_q;
    end
    rd_bit_q <= mem_q[index_i];
    rslot_q  <= in_slot_i;
  end

  // query answer: and of all probed bits, a slot without probe counts as set
  assign hit = ~rslot_q.probe | rd_bit_q;

  always_comb begin
    acc_d         = acc_q;
    res_valid_o   = 1'b0;
    res_present_o = acc_q & hit;
    if (rv_q && rslot_q.query) begin
      if (rslot_q.last) begin
        res_valid_o = 1'b1;
        acc_d       = 1'b1;
      end else begin
        acc_d = acc_q & hit;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_addr_q <= '0;
      rv_q       <= 1'b0;
      acc_q      <= 1'b1;
    end else begin
      clearing_q <= clearing_d;
      clr_addr_q <= clr_addr_d;
      rv_q       <= in_valid_i;
      acc_q      <= acc_d;
    end
  end

  assign busy_o = clearing_q;

endmodule

`default_nettype wire

>>> hdl/bloom_filter_insert_query.sv
// Bloom filter insert/query block, top level.
// Throughput: the probe sequencer issues one probe per cycle into the hash pipeline and
//   one bit-memory access per cycle while an item runs, and may load a new item in the
//   last slot of the current one; it stalls during the clearing pass or for result space.
// Reset: config registers return to filter_size 65536 and hash_count 7, capped at
//   FILTER_BITS and MAX_HASHES; a clearing pass zeroes the bit memory while full
//   stays high.
`default_nettype none

module bloom_filter_insert_query import bfiq_pkg::*; #(
  parameter int FILTER_BITS = DEF_FILTER_BITS,
  parameter int MAX_HASHES  = DEF_MAX_HASHES
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // command side
  input  wire logic                 push,
  output logic                      full,
  input  wire logic                 cmd_i,
  input  wire logic [KEY_W-1:0]     key_i,
  // result side
  output logic                      empty,
  input  wire logic                 pop,
  output logic                      present_o,
  // configuration write port
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i
);

  localparam int HC_W     = $clog2(MAX_HASHES + 1);
  localparam int MOD_W    = $clog2(FILTER_BITS + 1);
  localparam int AW       = $clog2(FILTER_BITS);
  localparam int SZ_CMP_W = (MOD_W > SIZE_REG_W) ? MOD_W : SIZE_REG_W;
  localparam int HC_CMP_W = (HC_W > HCNT_REG_W) ? HC_W : HCNT_REG_W;
  localparam int RST_MOD  = (RST_FILTER_SIZE > FILTER_BITS) ? FILTER_BITS : RST_FILTER_SIZE;
  localparam int RST_HC   = (RST_HASH_COUNT > MAX_HASHES) ? MAX_HASHES : RST_HASH_COUNT;
  localparam int CMDQ_W   = 1 + KEY_W;

  logic [MOD_W-1:0]    mod_q, mod_d;
  logic [HC_W-1:0]     hcnt_q, hcnt_d;
  logic [SZ_CMP_W-1:0] size_wr;
  logic [HC_CMP_W-1:0] hcnt_wr;

  logic                cmdq_full, cmdq_empty, cmdq_pop;
  logic [CMDQ_W-1:0]   cmdq_rdata;
  logic                store_busy;
  logic                res_pop;

  logic                seq_valid;
  slot_t               seq_slot;
  logic [KEY_W-1:0]    seq_key;
  logic [HC_W-1:0]     seq_probe;

  logic                hp_valid;
  slot_t               hp_slot;
  logic [AW-1:0]       hp_index;

  logic                res_valid, res_present;

  // configuration writes, saturated to the supported ranges
  assign size_wr = SZ_CMP_W'(cfg_data_i);
  assign hcnt_wr = HC_CMP_W'(cfg_data_i[HCNT_REG_W-1:0]);

  always_comb begin
    mod_d  = mod_q;
    hcnt_d = hcnt_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_FILTER_SIZE: begin
          if (size_wr < SZ_CMP_W'(MIN_FILTER_SIZE)) begin
            mod_d = MOD_W'(MIN_FILTER_SIZE);
          end else if (size_wr > SZ_CMP_W'(FILTER_BITS)) begin
            mod_d = MOD_W'(FILTER_BITS);
          end else begin
            mod_d = MOD_W'(size_wr);
          end
        end
        CFG_HASH_COUNT: begin
          if (hcnt_wr > HC_CMP_W'(MAX_HASHES)) begin
            hcnt_d = HC_W'(MAX_HASHES);
          end else begin
            hcnt_d = HC_W'(hcnt_wr);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q  <= MOD_W'(RST_MOD);
      hcnt_q <= HC_W'(RST_HC);
    end else begin
      mod_q  <= mod_d;
      hcnt_q <= hcnt_d;
    end
  end

  // front: command queue, closed while the clearing pass runs
  assign full = cmdq_full | store_busy;

  bfiq_fifo #(
    .WIDTH (CMDQ_W),
    .DEPTH (CMDQ_DEPTH)
  ) u_cmdq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push & ~full),
    .wdata_i ({cmd_i, key_i}),
    .full_o  (cmdq_full),
    .pop_i   (cmdq_pop),
    .rdata_o (cmdq_rdata),
    .empty_o (cmdq_empty)
  );

  // back: probe sequencer
  bfiq_probe_seq #(
    .MAX_HASHES (MAX_HASHES)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (~cmdq_empty),
    .item_cmd_i   (cmdq_rdata[CMDQ_W-1]),
    .item_key_i   (cmdq_rdata[KEY_W-1:0]),
    .item_pop_o   (cmdq_pop),
    .hash_count_i (hcnt_q),
    .store_busy_i (store_busy),
    .res_pop_i    (res_pop),
    .slot_valid_o (seq_valid),
    .slot_o       (seq_slot),
    .key_o        (seq_key),
    .probe_o      (seq_probe)
  );

  // back: hash and remainder pipeline
  bfiq_hash_pipe #(
    .FILTER_BITS (FILTER_BITS),
    .MAX_HASHES  (MAX_HASHES)
  ) u_hash (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (seq_valid),
    .in_slot_i   (seq_slot),
    .key_i       (seq_key),
    .probe_i     (seq_probe),
    .modulus_i   (mod_q),
    .out_valid_o (hp_valid),
    .out_slot_o  (hp_slot),
    .index_o     (hp_index)
  );

  // back: bit memory
  bfiq_bit_store #(
    .FILTER_BITS (FILTER_BITS)
  ) u_store (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (hp_valid),
    .in_slot_i     (hp_slot),
    .index_i       (hp_index),
    .busy_o        (store_busy),
    .res_valid_o   (res_valid),
    .res_present_o (res_present)
  );

  // result queue, space reserved by the sequencer before a query starts
  assign res_pop = pop & ~empty;

  bfiq_fifo #(
    .WIDTH (1),
    .DEPTH (RES_DEPTH)
  ) u_resq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .wdata_i (res_present),
    .full_o  (),
    .pop_i   (res_pop),
    .rdata_o (present_o),
    .empty_o (empty)
  );

endmodule

`default_nettype wire

>>> hdl/bfiq_checker.sv
// port level checks of the bloom filter block and their binding
`default_nettype none

module bfiq_checker import bfiq_pkg::*; (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic push,
  input wire logic full,
  input wire logic cmd_i,
  input wire logic empty,
  input wire logic pop,
  input wire logic present_o
);

  localparam int QMAX = CMDQ_DEPTH + RES_DEPTH;
  localparam int QC_W = $clog2(QMAX + 2);

  logic            q_in, q_out;
  logic [QC_W-1:0] qcnt_q;

  // queries transferred in and not yet transferred out
  assign q_in  = push & ~full & (op_e'(cmd_i) == OP_QUERY);
  assign q_out = pop & ~empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qcnt_q <= '0;
    end else if (q_in && !q_out) begin
      qcnt_q <= qcnt_q + QC_W'(1);
    end else if (!q_in && q_out) begin
      qcnt_q <= qcnt_q - QC_W'(1);
    end
  end

  // clearing pass holds off commands right after reset
  a_clear_after_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> full)
    else $error("command side open right after reset");

  // a result only exists for an outstanding query
  a_result_needs_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (qcnt_q != '0))
    else $error("result without a pending query");

  // outstanding queries stay within the queue capacity
  a_query_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qcnt_q <= QC_W'(QMAX))
    else $error("more queries outstanding than the block can hold");

  // a query is not answered in the cycle after its transfer
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_in && empty && (qcnt_q == '0)) |=> empty)
    else $error("query answered in the cycle after its transfer");

  // a waiting result holds until taken
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(present_o)))
    else $error("waiting result changed or vanished");

endmodule

bind bloom_filter_insert_query bfiq_checker u_bfiq_checker (.*);

`default_nettype wire
